[rtl/ffbp_pkg.sv]
// ----------------------------------------------------------------------------
// ffbp_pkg: shared types and constants
// Grid size, internal edge width, the ring control group passed from the scan
// controller to the column ring, and the controller status group.
// ----------------------------------------------------------------------------
`default_nettype none
package ffbp_pkg;

  localparam int GRID_ROWS   = 64;
  localparam int GRID_COLS   = 1024;
  localparam int COL_W       = $clog2(GRID_COLS);
  localparam int EDGE_W      = 18;
  localparam int BOUND_W_MAX = 2047;

  typedef logic [GRID_ROWS-1:0] row_t;

  typedef struct packed {
    logic shift;
    row_t tail_word;
  } ring_ctl_t;

  typedef struct packed {
    logic idle;
    logic aligned;
  } ctrl_stat_t;

endpackage
`default_nettype wire

[rtl/ffbp_if.sv]
// ----------------------------------------------------------------------------
// ffbp_if: input and result channels
// Valid/ready channels carrying one item word and one result word.
// ----------------------------------------------------------------------------
`default_nettype none
interface ffbp_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [9:0]  start_column;
  logic [10:0] tile_width;
  logic [6:0]  tile_height;
  logic [9:0]  offset_col;
  logic [5:0]  offset_row;

  modport source (output valid, operation, start_column, tile_width, tile_height,
                  offset_col, offset_row, input ready);
  modport sink (input valid, operation, start_column, tile_width, tile_height,
                offset_col, offset_row, output ready);
endinterface

interface ffbp_out_if;
  logic        valid;
  logic        ready;
  logic        placed;
  logic [9:0]  placed_column;
  logic [10:0] bound_width;
  logic [6:0]  bound_height;

  modport source (output valid, placed, placed_column, bound_width, bound_height,
                  input ready);
  modport sink (input valid, placed, placed_column, bound_width, bound_height,
                output ready);
endinterface
`default_nettype wire

[rtl/ffbp_cell.sv]
// ----------------------------------------------------------------------------
// ffbp_cell: one grid column
// Holds the occupancy word of one column and loads its neighbor on shift.
// ----------------------------------------------------------------------------
`default_nettype none
module ffbp_cell
  import ffbp_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  shift,
  input  row_t d,
  output row_t q
);

  row_t word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else if (shift) begin
      word_r <= d;
    end
  end

  assign q = word_r;

endmodule
`default_nettype wire

[rtl/ffbp_ring.sv]
// ----------------------------------------------------------------------------
// ffbp_ring: circulating column ring
// A chain of column cells; the head feeds the controller, whose word
// re-enters at the tail, so one full turn restores column order.
// ----------------------------------------------------------------------------
`default_nettype none
module ffbp_ring
  import ffbp_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  ring_ctl_t ctl,
  output row_t      head_word
);

  row_t q [GRID_COLS];

  for (genvar i = 0; i < GRID_COLS; i++) begin : g_cell
    if (i == GRID_COLS - 1) begin : g_tail
      ffbp_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(ctl.shift),
                        .d(ctl.tail_word), .q(q[i]));
    end else begin : g_body
      ffbp_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(ctl.shift),
                        .d(q[i+1]), .q(q[i]));
    end
  end

  assign head_word = q[0];

endmodule
`default_nettype wire

[rtl/ffbp_ctrl.sv]
// ----------------------------------------------------------------------------
// ffbp_ctrl: scan controller
// Accepts items, runs the search and mark turns of the ring, keeps the
// bounds and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none
module ffbp_ctrl
  import ffbp_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  ffbp_in_if.sink    in_chan,
  ffbp_out_if.source out_chan,
  input  row_t       head_word,
  output ring_ctl_t  ring_ctl,
  output ctrl_stat_t stat
);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_MARK, S_DONE} state_t;

  state_t            state_r;
  logic [COL_W-1:0]  col_r;
  logic [EDGE_W-1:0] run_r, mstart_r, mend_r, right_r, dx_r, w_r;
  logic [6:0]        bottom_r;
  row_t              mask_r;
  logic              found_r, ok_r;
  logic [9:0]        origin_r;
  logic [10:0]       wb_r;
  logic [6:0]        hb_r;
  logic              out_valid_r, out_placed_r;
  logic [9:0]        out_col_r;
  logic [10:0]       out_bw_r;
  logic [6:0]        out_bh_r;

  logic              accept, last_col, free, in_rng;
  logic              rows_ok, pre_ok, place_ok, out_load;
  logic [7:0]        bottom;
  row_t              mask;
  logic [EDGE_W-1:0] e_start, e_dx, e_w, right_pre, fit_pre, col_e, run_nxt, cnext;
  logic [10:0]       right_sat, wb_nxt;
  logic [6:0]        hb_nxt;

  assign accept    = in_chan.valid && in_chan.ready;
  assign bottom    = 8'(in_chan.offset_row) + 8'(in_chan.tile_height);
  assign mask      = (~({GRID_ROWS{1'b1}} << in_chan.tile_height)) << in_chan.offset_row;
  assign e_start   = EDGE_W'(in_chan.start_column);
  assign e_dx      = EDGE_W'(in_chan.offset_col);
  assign e_w       = EDGE_W'(in_chan.tile_width);
  assign right_pre = e_start + e_dx + e_w;
  assign fit_pre   = e_dx + e_w;
  assign rows_ok   = (bottom <= 8'(GRID_ROWS));
  assign pre_ok    = rows_ok && !in_chan.operation && (right_pre <= EDGE_W'(GRID_COLS));
  assign place_ok  = rows_ok && in_chan.operation && (fit_pre <= EDGE_W'(GRID_COLS));
  assign last_col  = (col_r == COL_W'(GRID_COLS - 1));
  assign col_e     = EDGE_W'(col_r);
  assign cnext     = col_e + EDGE_W'(1);
  assign free      = ((head_word & mask_r) == '0);
  assign run_nxt   = free ? run_r + EDGE_W'(1) : '0;
  assign in_rng    = (col_e >= mstart_r) && (col_e < mend_r);
  assign right_sat = (right_r > EDGE_W'(BOUND_W_MAX)) ? 11'(BOUND_W_MAX) : right_r[10:0];
  assign wb_nxt    = (ok_r && right_sat > wb_r) ? right_sat : wb_r;
  assign hb_nxt    = (ok_r && bottom_r > hb_r) ? bottom_r : hb_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  assign in_chan.ready = (state_r == S_IDLE);
  assign ring_ctl.shift = (state_r == S_SEARCH) || (state_r == S_MARK);
  assign ring_ctl.tail_word = (state_r == S_MARK && in_rng) ? (head_word | mask_r) : head_word;
  assign stat.idle    = (state_r == S_IDLE);
  assign stat.aligned = (col_r == '0);

  assign out_chan.valid         = out_valid_r;
  assign out_chan.placed        = out_placed_r;
  assign out_chan.placed_column = out_col_r;
  assign out_chan.bound_width   = out_bw_r;
  assign out_chan.bound_height  = out_bh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      found_r     <= 1'b0;
      ok_r        <= 1'b0;
      wb_r        <= '0;
      hb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.valid && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            mask_r   <= mask;
            bottom_r <= bottom[6:0];
            dx_r     <= e_dx;
            w_r      <= e_w;
            run_r    <= '0;
            found_r  <= 1'b0;
            if (pre_ok) begin
              ok_r     <= 1'b1;
              origin_r <= in_chan.start_column;
              mstart_r <= e_start + e_dx;
              mend_r   <= right_pre;
              right_r  <= right_pre;
              state_r  <= S_MARK;
            end else if (place_ok && in_chan.tile_width != '0) begin
              ok_r     <= 1'b0;
              origin_r <= '0;
              state_r  <= S_SEARCH;
            end else if (place_ok) begin
              ok_r     <= 1'b1;
              origin_r <= '0;
              right_r  <= e_dx;
              state_r  <= S_DONE;
            end else begin
              ok_r     <= 1'b0;
              origin_r <= '0;
              state_r  <= S_DONE;
            end
          end
        end
        S_SEARCH: begin
          if (!found_r && col_e >= dx_r) begin
            run_r <= run_nxt;
            if (run_nxt >= w_r) begin
              found_r  <= 1'b1;
              mstart_r <= cnext - w_r;
              mend_r   <= cnext;
              right_r  <= cnext;
              origin_r <= 10'(cnext - w_r - dx_r);
            end
          end
          col_r <= col_r + COL_W'(1);
          if (last_col) begin
            if (found_r || (col_e >= dx_r && run_nxt >= w_r)) begin
              ok_r    <= 1'b1;
              state_r <= S_MARK;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_MARK: begin
          col_r <= col_r + COL_W'(1);
          if (last_col) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            wb_r         <= wb_nxt;
            hb_r         <= hb_nxt;
            out_placed_r <= ok_r;
            out_col_r    <= ok_r ? origin_r : '0;
            out_bw_r     <= wb_nxt;
            out_bh_r     <= hb_nxt;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/first_fit_bitmap_tile_packer_top.sv]
// ----------------------------------------------------------------------------
// first_fit_bitmap_tile_packer_top: first-fit rectangle packer
// Flow: a rejected item or a zero-width place goes straight to the result; a
//   preplace runs one mark turn; a place with no free column runs one search
//   turn; a place that fits runs one search turn and one mark turn of the
//   column ring, one column per cycle through the ring head.
// Throughput: one item at a time; the next item can be taken only after the
//   result word is loaded; a waiting result word holds the next result.
// Reset: synchronous; clears every cell, both bounds and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_bitmap_tile_packer_top
  import ffbp_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  ffbp_in_if.sink    in_chan,
  ffbp_out_if.source out_chan
);

  ring_ctl_t  ring_ctl;
  row_t       head_word;
  ctrl_stat_t stat;

  ffbp_ring u_ring (
    .clk(clk), .rst_n(rst_n), .ctl(ring_ctl), .head_word(head_word)
  );

  ffbp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .head_word(head_word), .ring_ctl(ring_ctl), .stat(stat)
  );

`ifndef ASSERT_OFF
  a_idle_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    stat.idle |-> stat.aligned) else $error("ring not aligned while idle");

  a_idle_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
    stat.idle |-> !ring_ctl.shift) else $error("ring shifts while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !stat.idle) else $error("accept left idle");

  a_fail_col: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.placed) |-> (out_chan.placed_column == '0))
    else $error("failed word carries a column");
`endif

endmodule
`default_nettype wire
